[sv/two_missing_numbers_finder_unit_defines.svh]
// Assertion macros for the two-missing-numbers finder checker.
// No dependencies; included by the checker file only.
`ifndef TWO_MISSING_NUMBERS_FINDER_UNIT_DEFINES_SVH
`define TWO_MISSING_NUMBERS_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define TMNF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define TMNF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tmnf_pkg.sv]
// Shared widths, constants and helpers of the two-missing-numbers finder.
// No dependencies; used by the top level and its checker.
package tmnf_pkg;

    localparam int MAX_N_DEFAULT = 1024;

    // field and bus widths
    localparam int VALUE_W   = 11;
    localparam int S_TDATA_W = 16;   // value, padded to two bytes
    localparam int M_TDATA_W = 24;   // larger, smaller, padded to three bytes
    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 11'd1024;
    localparam logic [VALUE_W-1:0] N_FLOOR         = 11'd3;

    // accumulators (wrap at these widths)
    localparam int SUM_W = 20;
    localparam int SQ_W  = 29;

    // finish datapath
    localparam int FAC_W    = 12;    // n + 1, 2n + 1
    localparam int PROD_W   = 23;    // n(n+1)/2 class products
    localparam int EXPSQ_W  = 33;    // sum of squares 1..n, n <= 2047
    localparam int SQGAP_W  = 34;
    localparam int SUMGAP_W = 23;
    localparam int GSQ_W    = 45;
    localparam int RADF_W   = 47;
    localparam int RAD_W    = 34;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;

    // exact-enough divide by three: floor(x * 2731 / 8192)
    localparam int RECIP3       = 2731;
    localparam int RECIP3_SHIFT = 13;
    localparam int DIV3_W       = FAC_W + RECIP3_SHIFT;

    function automatic logic [FAC_W-1:0] div3(input logic [FAC_W-1:0] x);
        logic [DIV3_W-1:0] p;
        p = DIV3_W'(x) * DIV3_W'(RECIP3);
        return FAC_W'(p >> RECIP3_SHIFT);
    endfunction

endpackage

[sv/two_missing_numbers_finder_unit.sv]
// Two-missing-numbers finder: streaming top level with accumulators, finish
// sequencer and a two-bits-per-cycle square root. Depends on tmnf_pkg.
//
// The block takes the n-2 distinct values of 1..n that are present, one per
// s_ request, with n held in max_value (cfg port, clamped to [3, MAX_N]).
// While a set fills, one value is taken every cycle: a narrow 11x11 square
// feeds the running sum and sum of squares. The request that completes a set
// starts a finish sequence during which s_tready is low:
// seven single-multiply arithmetic steps (n mod 3, exact divide by three,
// two products for the expected sum of squares, expected sum and its gap,
// square of the sum gap, clamped radicand), then the digit-serial square
// root (two radicand bits in, one root bit out per cycle), then a final step
// that loads the result register. That step also waits while a
// previous result is still untaken. Results sit in an output register, so a
// new set is accepted while a result waits on m_tready. The sums wrap at 20
// and 29 bits; a set that breaks the distinct-values promise still yields a
// deterministic but meaningless pair. No memory, no clearing pass.
module two_missing_numbers_finder_unit #(
    parameter int MAX_N = tmnf_pkg::MAX_N_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config: max_value [10:0]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmnf_pkg::VALUE_W-1:0]   cfg_data,
    // s_tdata: value [10:0], zero pad [15:11]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tmnf_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: larger_missing [10:0], smaller_missing [21:11], zero pad [23:22]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tmnf_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int VW = tmnf_pkg::VALUE_W;

    // largest n the 11-bit register can reach under MAX_N
    localparam int N_CAP_INT = (MAX_N < 2047) ? MAX_N : 2047;
    localparam logic [VW-1:0] N_CAP = VW'(N_CAP_INT);
    // count stays below n-2
    localparam int CNT_W = $clog2(N_CAP_INT - 1);
    localparam int CMP_W = VW + 1;
    localparam int ITER_W = $clog2(tmnf_pkg::ROOT_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(tmnf_pkg::ROOT_W - 1);

    typedef enum logic [3:0] {
        ST_ACC,
        ST_MOD,
        ST_DIV,
        ST_PROD,
        ST_EXPSQ,
        ST_EXPSUM,
        ST_GSQ,
        ST_RAD,
        ST_ROOT,
        ST_OUT
    } state_t;

    // control
    state_t                          state_reg;
    logic [VW-1:0]                   max_value_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [tmnf_pkg::SUM_W-1:0]      sum_reg;
    logic [tmnf_pkg::SQ_W-1:0]       sq_reg;
    logic [ITER_W-1:0]               iter_reg;
    logic                            m_tvalid_reg;

    // finish payload
    logic [VW-1:0]                   n_reg;
    logic [tmnf_pkg::SUM_W-1:0]      sum_snap_reg;
    logic [tmnf_pkg::SQ_W-1:0]       sq_snap_reg;
    logic [1:0]                      mod3_reg;
    logic [tmnf_pkg::FAC_W-1:0]      fa_reg, fb_reg, fc_reg;
    logic [tmnf_pkg::PROD_W-1:0]     half_prod_reg;
    logic [tmnf_pkg::SQGAP_W-1:0]    sq_gap_reg;
    logic [tmnf_pkg::SUMGAP_W-1:0]   sum_gap_reg;
    logic [tmnf_pkg::GSQ_W-1:0]      gsq_reg;
    logic [tmnf_pkg::RAD_W-1:0]      rad_reg;
    logic [tmnf_pkg::REM_W-1:0]      rem_reg;
    logic [tmnf_pkg::ROOT_W-1:0]     root_reg;
    logic [tmnf_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    // accumulate path
    logic                            s_acc;
    logic [VW-1:0]                   in_value;
    logic [2*VW-1:0]                 in_square;
    logic [VW-1:0]                   n_eff;
    logic [VW-1:0]                   target;
    logic [CMP_W-1:0]                cnt_inc;
    logic                            set_done;
    logic [tmnf_pkg::SUM_W-1:0]      sum_next;
    logic [tmnf_pkg::SQ_W-1:0]       sq_next;

    // finish path
    logic [tmnf_pkg::FAC_W-1:0]      n_ext, n_plus1, n_twice1;
    logic [tmnf_pkg::FAC_W-1:0]      n_third;
    logic [tmnf_pkg::FAC_W-1:0]      mod3_full;
    logic [tmnf_pkg::FAC_W-1:0]      div_in, div_out;
    logic [2*tmnf_pkg::FAC_W-1:0]    fab_prod;
    logic [tmnf_pkg::PROD_W+tmnf_pkg::FAC_W-1:0] expsq_full;
    logic [2*tmnf_pkg::FAC_W-1:0]    nn1_prod;
    logic signed [2*tmnf_pkg::SUMGAP_W-1:0] gsq_full;
    logic signed [tmnf_pkg::RADF_W-1:0]     rad_full;
    logic [tmnf_pkg::REM_W+1:0]      rem_try, root_trial;
    logic                            root_bit;
    logic signed [tmnf_pkg::SUMGAP_W:0]     gap_plus_diff;
    logic signed [tmnf_pkg::SUMGAP_W:0]     larger_full, smaller_full;
    logic                            out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_ACC);
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---- accumulate ----
    always_comb begin
        in_value  = s_tdata[VW-1:0];
        in_square = (2*VW)'(in_value) * (2*VW)'(in_value);
        if (max_value_reg < tmnf_pkg::N_FLOOR) begin
            n_eff = tmnf_pkg::N_FLOOR;
        end else if (max_value_reg > N_CAP) begin
            n_eff = N_CAP;
        end else begin
            n_eff = max_value_reg;
        end
        target   = n_eff - VW'(2);
        cnt_inc  = CMP_W'(count_reg) + CMP_W'(1);
        set_done = (cnt_inc >= CMP_W'(target));
        sum_next = sum_reg + tmnf_pkg::SUM_W'(in_value);
        sq_next  = sq_reg + tmnf_pkg::SQ_W'(in_square);
    end

    // ---- finish arithmetic, one multiply per step ----
    always_comb begin
        n_ext     = tmnf_pkg::FAC_W'(n_reg);
        n_plus1   = n_ext + tmnf_pkg::FAC_W'(1);
        n_twice1  = {n_ext[tmnf_pkg::FAC_W-2:0], 1'b1};
        n_third   = tmnf_pkg::div3(n_ext);
        mod3_full = n_ext - {n_third[tmnf_pkg::FAC_W-2:0], 1'b0} - n_third;

        // the factor that three divides: n, 2n+1 or n+1 for n mod 3 = 0, 1, 2
        case (mod3_reg)
            2'd0:    div_in = n_ext;
            2'd1:    div_in = n_twice1;
            default: div_in = n_plus1;
        endcase
        div_out = tmnf_pkg::div3(div_in);

        fab_prod   = (2*tmnf_pkg::FAC_W)'(fa_reg) * (2*tmnf_pkg::FAC_W)'(fb_reg);
        expsq_full = (tmnf_pkg::PROD_W+tmnf_pkg::FAC_W)'(half_prod_reg)
                   * (tmnf_pkg::PROD_W+tmnf_pkg::FAC_W)'(fc_reg);
        nn1_prod   = (2*tmnf_pkg::FAC_W)'(n_ext) * (2*tmnf_pkg::FAC_W)'(n_plus1);

        gsq_full = $signed(sum_gap_reg) * $signed(sum_gap_reg);
        rad_full = (tmnf_pkg::RADF_W'($signed(sq_gap_reg)) <<< 1)
                 - $signed({2'b00, gsq_reg});

        // one root digit: bring down two radicand bits, try root*4+1
        rem_try    = {rem_reg, rad_reg[tmnf_pkg::RAD_W-1 -: 2]};
        root_trial = (tmnf_pkg::REM_W+2)'({root_reg, 2'b01});
        root_bit   = (rem_try >= root_trial);

        // (gap + root) / 2 truncated toward zero
        gap_plus_diff = (tmnf_pkg::SUMGAP_W+1)'($signed(sum_gap_reg))
                      + $signed({2'b00, root_reg});
        larger_full   = (gap_plus_diff
                        + $signed({{tmnf_pkg::SUMGAP_W{1'b0}},
                                   gap_plus_diff[tmnf_pkg::SUMGAP_W] & gap_plus_diff[0]}))
                        >>> 1;
        smaller_full  = (tmnf_pkg::SUMGAP_W+1)'($signed(sum_gap_reg)) - larger_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            max_value_reg <= tmnf_pkg::MAX_VALUE_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            iter_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_value_reg <= cfg_data;
            end
            // in ST_OUT the result load below owns m_tvalid_reg
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_ACC: begin
                    if (s_acc) begin
                        if (set_done) begin
                            // snapshot and clear for the next set
                            n_reg        <= n_eff;
                            sum_snap_reg <= sum_next;
                            sq_snap_reg  <= sq_next;
                            count_reg    <= '0;
                            sum_reg      <= '0;
                            sq_reg       <= '0;
                            state_reg    <= ST_MOD;
                        end else begin
                            count_reg <= cnt_inc[CNT_W-1:0];
                            sum_reg   <= sum_next;
                            sq_reg    <= sq_next;
                        end
                    end
                end
                ST_MOD: begin
                    mod3_reg  <= mod3_full[1:0];
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    fa_reg <= (mod3_reg == 2'd0) ? div_out : n_ext;
                    fb_reg <= (mod3_reg == 2'd2) ? div_out : n_plus1;
                    fc_reg <= (mod3_reg == 2'd1) ? div_out : n_twice1;
                    state_reg <= ST_PROD;
                end
                ST_PROD: begin
                    // product of the first two factors is even
                    half_prod_reg <= fab_prod[tmnf_pkg::PROD_W:1];
                    state_reg     <= ST_EXPSQ;
                end
                ST_EXPSQ: begin
                    sq_gap_reg <= tmnf_pkg::SQGAP_W'(expsq_full[tmnf_pkg::EXPSQ_W-1:0])
                                - tmnf_pkg::SQGAP_W'(sq_snap_reg);
                    state_reg  <= ST_EXPSUM;
                end
                ST_EXPSUM: begin
                    sum_gap_reg <= nn1_prod[tmnf_pkg::SUMGAP_W:1]
                                 - tmnf_pkg::SUMGAP_W'(sum_snap_reg);
                    state_reg   <= ST_GSQ;
                end
                ST_GSQ: begin
                    gsq_reg   <= gsq_full[tmnf_pkg::GSQ_W-1:0];
                    state_reg <= ST_RAD;
                end
                ST_RAD: begin
                    rad_reg   <= rad_full[tmnf_pkg::RADF_W-1] ? '0
                                 : rad_full[tmnf_pkg::RAD_W-1:0];
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    iter_reg  <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    rem_reg  <= root_bit ? tmnf_pkg::REM_W'(rem_try - root_trial)
                                         : tmnf_pkg::REM_W'(rem_try);
                    root_reg <= {root_reg[tmnf_pkg::ROOT_W-2:0], root_bit};
                    rad_reg  <= {rad_reg[tmnf_pkg::RAD_W-3:0], 2'b00};
                    iter_reg <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_LAST) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {2'b00, smaller_full[VW-1:0], larger_full[VW-1:0]};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_ACC;
                    end
                end
                default: begin
                    state_reg <= ST_ACC;
                end
            endcase
        end
    end

endmodule

[sv/tmnf_checker.sv]
// Port-level checker for the two-missing-numbers finder, bound to the top.
// Depends on tmnf_pkg and two_missing_numbers_finder_unit_defines.svh.
`include "two_missing_numbers_finder_unit_defines.svh"

module tmnf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tmnf_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    `TMNF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // input closes only after the request that completes a set
    `TMNF_ASSERT_IMP(a_close_on_req, $fell(s_tready), $past(s_tvalid && s_tready), "input closed without a request")

    // input reopens exactly when a result is loaded
    `TMNF_ASSERT_IMP(a_reopen_result, $rose(s_tready), m_tvalid, "input reopened without a result")

    // the finish sequence separates the last request from its result
    `TMNF_ASSERT_IMP(a_no_fast_result, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result right after a request")

endmodule

bind two_missing_numbers_finder_unit tmnf_checker u_tmnf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/two_missing_numbers_finder_unit_test.sv]
// Self-checking bench for the two-missing-numbers finder: streams sets of values,
// predicts each missing pair from running sums and checks every result in order.
// Depends on tmnf_pkg and two_missing_numbers_finder_unit.
module two_missing_numbers_finder_unit_test;

    localparam int VALUE_W         = tmnf_pkg::VALUE_W;
    localparam int S_TDATA_W       = tmnf_pkg::S_TDATA_W;
    localparam int M_TDATA_W       = tmnf_pkg::M_TDATA_W;
    localparam int SUM_W           = tmnf_pkg::SUM_W;
    localparam int SQ_W            = tmnf_pkg::SQ_W;
    localparam int MAX_N_DEFAULT   = tmnf_pkg::MAX_N_DEFAULT;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = tmnf_pkg::MAX_VALUE_RESET;

    localparam int CLK_PERIOD     = 12;
    localparam int RUN_CAP_CYCLES = 400000;
    localparam int LIMIT_CAP      = MAX_N_DEFAULT;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 200;
    localparam int RANDOM_VALUES  = 40;
    localparam int RANDOM_SETS    = 8;

    typedef struct packed {
        logic [VALUE_W-1:0] larger;
        logic [VALUE_W-1:0] smaller;
    } missing_pair_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [VALUE_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // value [10:0], zero pad [15:11]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // larger [10:0], smaller [21:11], pad

    two_missing_numbers_finder_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of n and of the running count and sums
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] limit_reg = MAX_VALUE_RESET;
    int                 set_fill  = 0;
    logic [SUM_W-1:0]   run_sum   = '0;
    logic [SQ_W-1:0]    run_sq    = '0;
    missing_pair_t      missing_pairs[$];   // pairs owed by the block, oldest first

    int values_taken  = 0;
    int pairs_checked = 0;
    int limit_writes  = 0;
    int err_count     = 0;

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    // Accumulate one accepted value; on set completion derive the pair from
    // sum gap S and square-sum gap Q: D = isqrt(max(0, 2Q - S^2)).
    task automatic absorb_value(input logic [VALUE_W-1:0] v);
        longint        n, exp_s, exp_q, acc_s, acc_q;
        longint        gap_s, gap_q, rad, d, big, sml;
        missing_pair_t p;
        n = limit_reg;
        if (n < 3) n = 3;
        if (n > LIMIT_CAP) n = LIMIT_CAP;
        run_sum  = run_sum + SUM_W'(v);
        run_sq   = run_sq + SQ_W'(v) * SQ_W'(v);
        set_fill = set_fill + 1;
        if (set_fill >= n - 2) begin
            acc_s = run_sum;
            acc_q = run_sq;
            exp_s = n * (n + 1) / 2;
            exp_q = n * (n + 1) * (2 * n + 1) / 6;
            gap_s = exp_s - acc_s;
            gap_q = exp_q - acc_q;
            rad   = 2 * gap_q - gap_s * gap_s;
            if (rad < 0) rad = 0;
            d   = longint'(floor_root(rad));
            big = (gap_s + d) / 2;          // truncates toward zero
            sml = gap_s - big;
            p.larger  = big[VALUE_W-1:0];
            p.smaller = sml[VALUE_W-1:0];
            missing_pairs.push_back(p);
            set_fill = 0;
            run_sum  = '0;
            run_sq   = '0;
        end
    endtask

    task automatic check_pair(input logic [M_TDATA_W-1:0] word);
        missing_pair_t want;
        logic [VALUE_W-1:0] got_larger, got_smaller;
        got_larger  = word[VALUE_W-1:0];
        got_smaller = word[2*VALUE_W-1:VALUE_W];
        if (missing_pairs.size() == 0) begin
            $display("%0t: result with no set pending: larger %0d smaller %0d",
                     $time, got_larger, got_smaller);
            err_count++;
        end else begin
            want = missing_pairs.pop_front();
            pairs_checked++;
            if (got_larger !== want.larger) begin
                $display("%0t: larger_missing mismatch: expected %0d, actual %0d",
                         $time, want.larger, got_larger);
                err_count++;
            end
            if (got_smaller !== want.smaller) begin
                $display("%0t: smaller_missing mismatch: expected %0d, actual %0d",
                         $time, want.smaller, got_smaller);
                err_count++;
            end
        end
    endtask

    // Monitor: every handshake is seen at the rising edge.
    logic s_took = 1'b0;

    always @(posedge aclk) begin : observe
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg = cfg_data;
                limit_writes++;
            end
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                absorb_value(s_tdata[VALUE_W-1:0]);
                values_taken++;
            end
            if (m_tvalid && m_tready) check_pair(m_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Sender: pops the backlog at the falling edge, idles in bursts
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] value_backlog[$];
    int s_idle_pct = 0;
    int s_gap      = 0;

    always @(negedge aclk) begin : feed
        if (aresetn && (!s_tvalid || s_took)) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (value_backlog.size() > 0) begin
                s_tdata  <= S_TDATA_W'(value_backlog.pop_front());
                s_tvalid <= 1'b1;
                if ($urandom_range(99) < s_idle_pct) s_gap = $urandom_range(1, 9);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus long hold-offs on request, so the
    // output register fills, the finish waits and s_tready drops.
    int m_idle_pct   = 0;
    int m_gap        = 0;
    int m_hold       = 0;
    int holds_wanted = 0;
    int holds_done   = 0;

    always @(negedge aclk) begin : take_results
        if (aresetn) begin
            if (holds_done < holds_wanted) begin
                holds_done++;
                m_hold = LONG_HOLD;
            end
            if (m_hold > 0) begin
                m_hold--;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(99) < m_idle_pct) m_gap = $urandom_range(1, 9);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation; gen_fill tracks the set boundary the block sees
    // ------------------------------------------------------------------
    int gen_n         = LIMIT_CAP;
    int gen_fill      = 0;
    int values_queued = 0;
    int sets_queued   = 0;

    function automatic int clamp_n(input int raw);
        if (raw < 3) return 3;
        if (raw > LIMIT_CAP) return LIMIT_CAP;
        return raw;
    endfunction

    task automatic push_value(input logic [VALUE_W-1:0] v);
        value_backlog.push_back(v);
        values_queued++;
        gen_fill++;
        if (gen_fill >= gen_n - 2) begin
            gen_fill = 0;
            sets_queued++;
        end
    endtask

    // All requests accepted, all pairs delivered, then a settle pause.
    task automatic wait_idle();
        do @(negedge aclk);
        while (values_taken != values_queued || missing_pairs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [VALUE_W-1:0] raw);
        wait_idle();
        cfg_data  <= raw;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        gen_n = clamp_n(raw);
    endtask

    // Close a set left open by a change of n, with in-range values.
    task automatic close_open_set();
        while (gen_fill != 0) push_value(VALUE_W'($urandom_range(1, gen_n)));
    endtask

    // Shuffled 1..n without two distinct values; optionally spoil one entry
    // with a repeat or an arbitrary 11-bit value.
    task automatic push_set(input bit spoil);
        int a, b, j, tmp;
        int members[$];
        close_open_set();
        a = $urandom_range(1, gen_n);
        do b = $urandom_range(1, gen_n);
        while (b == a);
        for (int v = 1; v <= gen_n; v++)
            if (v != a && v != b) members.push_back(v);
        for (int i = members.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = members[i];
            members[i] = members[j];
            members[j] = tmp;
        end
        if (spoil) begin
            j = $urandom_range(0, members.size() - 1);
            if ($urandom_range(1) == 1 && members.size() > 1)
                members[j] = members[(j + 1) % members.size()];
            else
                members[j] = $urandom_range(0, 2047);
        end
        foreach (members[i]) push_value(VALUE_W'(members[i]));
    endtask

    task automatic push_noise(input int cnt);
        repeat (cnt) push_value(VALUE_W'($urandom_range(0, 2047)));
    endtask

    initial begin : watchdog
        #(CLK_PERIOD * RUN_CAP_CYCLES);
        $display("tb: failure");
        $finish;
    end

    initial begin : run
        int r, room, random_base, sets_base;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: limit 0 clamps to 3, one value per set, field extremes
        // and out-of-range values.
        write_limit(VALUE_W'(0));
        push_value(VALUE_W'(1));
        push_value(VALUE_W'(2));
        push_value(VALUE_W'(3));
        push_value(VALUE_W'(0));
        push_value(VALUE_W'(2047));
        push_value(VALUE_W'(1024));

        // n = 5: a good set, then a set of repeats.
        write_limit(VALUE_W'(5));
        push_set(1'b0);
        push_value(VALUE_W'(2));
        push_value(VALUE_W'(2));
        push_value(VALUE_W'(2));

        // n lowered mid-set: 4 of 8 taken, n -> 6, the next value completes.
        write_limit(VALUE_W'(10));
        push_value(VALUE_W'(1));
        push_value(VALUE_W'(2));
        push_value(VALUE_W'(3));
        push_value(VALUE_W'(4));
        write_limit(VALUE_W'(6));
        push_value(VALUE_W'(5));
        push_set(1'b0);

        write_limit(VALUE_W'(4));
        push_set(1'b0);

        // Largest n: above-range limit clamps to MAX_N, one full set.
        write_limit(VALUE_W'(2047));
        s_idle_pct = 3;
        m_idle_pct = 10;
        push_set(1'b0);

        // Back-pressure: results pile up behind a long receiver hold.
        write_limit(VALUE_W'(3));
        s_idle_pct = 0;
        m_idle_pct = 0;
        holds_wanted++;
        repeat (12) push_set(1'b0);

        // Random phases.
        random_base = values_queued;
        sets_base   = sets_queued;
        while (values_queued - random_base < RANDOM_VALUES ||
               sets_queued - sets_base < RANDOM_SETS) begin
            r = $urandom_range(99);
            case ($urandom_range(2))
                0: s_idle_pct = 0;
                1: s_idle_pct = 8;
                default: s_idle_pct = 20;
            endcase
            case ($urandom_range(2))
                0: m_idle_pct = 0;
                1: m_idle_pct = 10;
                default: m_idle_pct = 25;
            endcase
            if (r < 10) begin
                // limit above range, left part-filled; the next smaller n
                // closes it early
                write_limit(VALUE_W'($urandom_range(1025, 2047)));
                repeat ($urandom_range(1, 20)) push_value(VALUE_W'($urandom_range(1, 1024)));
            end else begin
                if (r < 15) write_limit(VALUE_W'($urandom_range(0, 2)));
                else if (r < 30) write_limit(VALUE_W'($urandom_range(25, 64)));
                else write_limit(VALUE_W'($urandom_range(3, 24)));
                repeat ($urandom_range(1, 4)) begin
                    r = $urandom_range(99);
                    if (r < 80) push_set(1'b0);
                    else if (r < 92) push_set(1'b1);
                    else push_noise($urandom_range(1, 6));
                end
                room = gen_n - 2 - gen_fill;
                if ($urandom_range(99) < 20 && room > 1)
                    repeat ($urandom_range(1, room - 1))
                        push_value(VALUE_W'($urandom_range(1, gen_n)));
            end
        end

        // Closing stretch without idling on either side.
        write_limit(VALUE_W'($urandom_range(3, 24)));
        s_idle_pct = 0;
        m_idle_pct = 0;
        repeat (3) push_set(1'b0);
        wait_idle();

        if (missing_pairs.size() != 0) begin
            $display("%0t: %0d missing pairs never delivered", $time, missing_pairs.size());
            err_count++;
        end
        $display("tb: streamed %0d values, checked %0d missing pairs, %0d mismatches",
                 values_taken, pairs_checked, err_count);
        $display("tb: %0d limit writes, n from 3 to %0d incl. clamping, mid-set change, stalls",
                 limit_writes, LIMIT_CAP);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
